// ===== hw/rtl/bpq_pkg.sv =====
package bpq_pkg;

    localparam int PRIO_W         = 4;
    localparam int ELEM_PORT_W    = 32;
    localparam int SIZE_W         = 9;
    localparam int LEVELS         = 16;
    localparam int CAPACITY_DEF   = 256;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam logic [PRIO_W-1:0] MAX_LEVEL_RST = 4'd15;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_ENQ   = 2'd1,
        OP_DEQ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_PRIO_HIGH = 2'd3
    } status_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/bucketed_priority_fifo_queue_core.sv =====
// Priority queue, FIFO order within each level, level 0 served first. Entries sit in a
// row of CAPACITY cells kept sorted by level; the head is always in the first cell. For each
// item, the accept edge captures the command and raises busy for one
// cycle, during which the whole cell row shifts in one step (insert or pop); done then
// pulses for one cycle with the result, and a new start is taken in that same cycle.
// Results cannot be held off: sample them whenever done is high. Write max_level via
// cfg_we/cfg_data only while no item is in flight.
module bucketed_priority_fifo_queue_core #(
    parameter int CAPACITY   = bpq_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = bpq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      op,
    input  logic [bpq_pkg::ELEM_PORT_W-1:0] elem,
    input  logic [bpq_pkg::PRIO_W-1:0]      priority_req,
    input  logic                            cfg_we,
    input  logic [bpq_pkg::PRIO_W-1:0]      cfg_data,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [bpq_pkg::SIZE_W-1:0]      size,
    output logic                            empty_res,
    output logic [bpq_pkg::ELEM_PORT_W-1:0] head_elem,
    output logic [bpq_pkg::PRIO_W-1:0]      head_priority
);

    localparam int STORE_W = (ELEM_WIDTH < bpq_pkg::ELEM_PORT_W) ? ELEM_WIDTH
                                                               : bpq_pkg::ELEM_PORT_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [1:0]                 op_reg;
    logic [STORE_W-1:0]         elem_reg;
    logic [bpq_pkg::PRIO_W-1:0] prio_reg;
    logic [bpq_pkg::PRIO_W-1:0] max_level_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    bpq_pkg::status_t           status_reg;
    bpq_pkg::status_t           status_next;
    logic                       accept;
    logic                       prio_bad;
    bpq_pkg::cell_ctrl_t        ctrl;

    logic [CAPACITY-1:0]        cv;
    logic [bpq_pkg::PRIO_W-1:0] cp [CAPACITY];
    logic [STORE_W-1:0]         ce [CAPACITY];

    assign accept   = start && !busy_reg;
    assign prio_bad = (prio_reg > max_level_reg)
                   || (9'(prio_reg) >= 9'(bpq_pkg::LEVELS));

    always_comb
    begin
        status_next = bpq_pkg::ST_OK;
        if (op_reg == bpq_pkg::OP_ENQ)
        begin
            if (prio_bad)
                status_next = bpq_pkg::ST_PRIO_HIGH;
            else if (count_reg == CNT_W'(CAPACITY))
                status_next = bpq_pkg::ST_FULL;
        end
        else if (op_reg == bpq_pkg::OP_DEQ)
        begin
            if (count_reg == '0)
                status_next = bpq_pkg::ST_EMPTY;
        end
    end

    always_comb
    begin
        ctrl.enq   = busy_reg && (op_reg == bpq_pkg::OP_ENQ) && (status_next == bpq_pkg::ST_OK);
        ctrl.deq   = busy_reg && (op_reg == bpq_pkg::OP_DEQ) && (status_next == bpq_pkg::ST_OK);
        ctrl.prio  = prio_reg;
        count_next = count_reg;
        if (ctrl.enq)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.deq)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            max_level_reg <= bpq_pkg::MAX_LEVEL_RST;
            status_reg    <= bpq_pkg::ST_OK;
        end
        else
        begin
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            count_reg <= count_next;
            if (cfg_we)
                max_level_reg <= cfg_data;
            if (busy_reg)
                status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            elem_reg <= elem[STORE_W-1:0];
            prio_reg <= priority_req;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                       pv;
        logic [bpq_pkg::PRIO_W-1:0] pp;
        logic [STORE_W-1:0]         pe;
        logic                       nv;
        logic [bpq_pkg::PRIO_W-1:0] np;
        logic [STORE_W-1:0]         ne;

        if (g == 0)
        begin : g_first
            // nothing ahead of the head: it counts as an entry of the most urgent level
            assign pv = 1'b1;
            assign pp = '0;
            assign pe = '0;
        end
        else
        begin : g_mid
            assign pv = cv[g-1];
            assign pp = cp[g-1];
            assign pe = ce[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign nv = 1'b0;
            assign np = '0;
            assign ne = '0;
        end
        else
        begin : g_body
            assign nv = cv[g+1];
            assign np = cp[g+1];
            assign ne = ce[g+1];
        end

        bpq_cell #(
            .ELEM_W (STORE_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_elem   (elem_reg),
            .prev_valid (pv),
            .prev_prio  (pp),
            .prev_elem  (pe),
            .next_valid (nv),
            .next_prio  (np),
            .next_elem  (ne),
            .valid      (cv[g]),
            .prio       (cp[g]),
            .elem       (ce[g])
        );
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign size          = bpq_pkg::SIZE_W'(count_reg);
    assign empty_res     = (count_reg == '0);
    assign head_elem     = cv[0] ? bpq_pkg::ELEM_PORT_W'(ce[0]) : '0;
    assign head_priority = cv[0] ? cp[0] : '0;

endmodule

// ===== hw/rtl/bpq_cell.sv =====
module bpq_cell #(
    parameter int ELEM_W = bpq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bpq_pkg::cell_ctrl_t        ctrl,
    input  logic [ELEM_W-1:0]          new_elem,
    input  logic                       prev_valid,
    input  logic [bpq_pkg::PRIO_W-1:0] prev_prio,
    input  logic [ELEM_W-1:0]          prev_elem,
    input  logic                       next_valid,
    input  logic [bpq_pkg::PRIO_W-1:0] next_prio,
    input  logic [ELEM_W-1:0]          next_elem,
    output logic                       valid,
    output logic [bpq_pkg::PRIO_W-1:0] prio,
    output logic [ELEM_W-1:0]          elem
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [bpq_pkg::PRIO_W-1:0] prio_reg;
    logic [bpq_pkg::PRIO_W-1:0] prio_next;
    logic [ELEM_W-1:0]          elem_reg;
    logic [ELEM_W-1:0]          elem_next;
    logic                       behind_new;
    logic                       prev_ahead;

    // the new item goes in front of strictly lower-urgency entries only,
    // so equal levels keep arrival order
    assign behind_new = !valid_reg || (prio_reg > ctrl.prio);
    assign prev_ahead = prev_valid && (prev_prio <= ctrl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        elem_next  = elem_reg;
        if (ctrl.deq)
        begin
            valid_next = next_valid;
            prio_next  = next_prio;
            elem_next  = next_elem;
        end
        else if (ctrl.enq && behind_new)
        begin
            if (prev_ahead)
            begin
                valid_next = 1'b1;
                prio_next  = ctrl.prio;
                elem_next  = new_elem;
            end
            else
            begin
                valid_next = prev_valid;
                prio_next  = prev_prio;
                elem_next  = prev_elem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        elem_reg <= elem_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign elem  = elem_reg;

endmodule

// ===== hw/rtl/bpq_chk.sv =====
module bpq_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [1:0]                      status,
    input logic                            empty_res,
    input logic [bpq_pkg::ELEM_PORT_W-1:0] head_elem,
    input logic [bpq_pkg::PRIO_W-1:0]      head_priority
);

    // each transfer in keeps busy high for exactly one cycle
    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 !busy)
        else $error("busy not a single cycle after a transfer in");

    // a result follows the busy cycle directly
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("no result after busy cycle");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_res |-> head_elem == '0 && head_priority == '0)
        else $error("empty queue reports a head");

    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == bpq_pkg::ST_EMPTY |-> empty_res)
        else $error("empty reject on a non-empty queue");

endmodule

bind bucketed_priority_fifo_queue_core bpq_chk u_bpq_chk (.*);

// ===== bench/tb_bucketed_priority_fifo_queue_core.sv =====
`timescale 1ns / 1ps

module tb_bucketed_priority_fifo_queue_core;

    import bpq_pkg::*;

    localparam int             CYCLE_LIMIT = 400000;
    localparam int             STORE_DEPTH = CAPACITY_DEF;
    localparam logic [1:0]     OP_SPARE    = 2'd3;   // unused code, behaves as a query
    localparam logic [31:0]    ALL_ONES    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        K_ITEM,
        K_CFG,
        K_HOLD
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        logic [1:0]        op;
        logic [31:0]       elem;
        logic [PRIO_W-1:0] prio;     // also carries the max_level value for K_CFG
    } step_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIZE_W-1:0] size;
        logic              empty;
        logic [31:0]       head_elem;
        logic [PRIO_W-1:0] head_prio;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             op = OP_QUERY;
    logic [ELEM_PORT_W-1:0] elem = '0;
    logic [PRIO_W-1:0]      priority_req = '0;
    logic                   cfg_we = 1'b0;
    logic [PRIO_W-1:0]      cfg_data = '0;
    logic                   done;
    logic [1:0]             status;
    logic [SIZE_W-1:0]      size;
    logic                   empty_res;
    logic [ELEM_PORT_W-1:0] head_elem;
    logic [PRIO_W-1:0]      head_priority;

    step_t    pending_steps[$];
    outcome_t due_results[$];

    // queue model: one FIFO per level
    logic [31:0]       level_fifo[LEVELS][$];
    int                stored = 0;
    logic [PRIO_W-1:0] cur_max_level = MAX_LEVEL_RST;

    int sent_cnt = 0;
    int taken_cnt = 0;
    int results_seen = 0;
    int errors = 0;
    int cycle_cnt = 0;
    int gap_left = 0;
    int calm_left = 0;
    int settle = 2;

    bucketed_priority_fifo_queue_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .elem          (elem),
        .priority_req  (priority_req),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .size          (size),
        .empty_res     (empty_res),
        .head_elem     (head_elem),
        .head_priority (head_priority)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic outcome_t apply_request(logic [1:0] op_v, logic [31:0] elem_v,
                                               logic [PRIO_W-1:0] prio_v);
        outcome_t r;
        int       lv;
        r.status = ST_OK;
        if (op_v == OP_ENQ)
        begin
            if (prio_v > cur_max_level)
                r.status = ST_PRIO_HIGH;
            else if (stored >= STORE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                level_fifo[prio_v].push_back(elem_v);
                stored++;
            end
        end
        else if (op_v == OP_DEQ)
        begin
            if (stored == 0)
                r.status = ST_EMPTY;
            else
            begin
                lv = 0;
                while (level_fifo[lv].size() == 0)
                    lv++;
                void'(level_fifo[lv].pop_front());
                stored--;
            end
        end
        r.size      = SIZE_W'(stored);
        r.empty     = (stored == 0);
        r.head_elem = '0;
        r.head_prio = '0;
        for (lv = LEVELS - 1; lv >= 0; lv--)
        begin
            if (level_fifo[lv].size() != 0)
            begin
                r.head_elem = level_fifo[lv][0];
                r.head_prio = PRIO_W'(lv);
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s of result %0d: got 0x%0h, expected 0x%0h",
                 field, results_seen, got, want);
        errors++;
    endtask

    task automatic add_item(logic [1:0] op_v, logic [31:0] elem_v, logic [PRIO_W-1:0] prio_v);
        step_t s;
        s.kind = K_ITEM;
        s.op   = op_v;
        s.elem = elem_v;
        s.prio = prio_v;
        pending_steps.push_back(s);
    endtask

    // wait for the queue to settle, then write max_level
    task automatic add_level_write(logic [PRIO_W-1:0] value);
        step_t s;
        s.kind = K_HOLD;
        s.op   = OP_QUERY;
        s.elem = '0;
        s.prio = '0;
        pending_steps.push_back(s);
        s.kind = K_CFG;
        s.prio = value;
        pending_steps.push_back(s);
    endtask

    task automatic add_random(int enq_pct, int deq_pct, logic [PRIO_W-1:0] maxl);
        int                pick;
        logic [1:0]        op_v;
        logic [31:0]       elem_v;
        logic [PRIO_W-1:0] prio_v;
        pick = $urandom_range(0, 99);
        if (pick < enq_pct)
            op_v = OP_ENQ;
        else if (pick < enq_pct + deq_pct)
            op_v = OP_DEQ;
        else
            op_v = ($urandom_range(0, 1) != 0) ? OP_SPARE : OP_QUERY;
        case ($urandom_range(0, 7))
            0:       elem_v = '0;
            1:       elem_v = ALL_ONES;
            default: elem_v = $urandom;
        endcase
        if ($urandom_range(0, 4) != 0)
            prio_v = PRIO_W'($urandom_range(0, maxl));
        else
            prio_v = PRIO_W'($urandom_range(0, LEVELS - 1));
        add_item(op_v, elem_v, prio_v);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        logic nxt_start;
        logic nxt_we;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (rst_n)
        begin
            if (start && taken_cnt == sent_cnt)
            begin
                nxt_start = 1'b0;
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap_left = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 13);
                    if ($urandom_range(0, 49) == 0)
                        calm_left = $urandom_range(20, 60);
                end
            end
            if (!nxt_start && !cfg_we)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_steps.size() != 0)
                begin
                    case (pending_steps[0].kind)
                        K_ITEM:
                        begin
                            op           <= pending_steps[0].op;
                            elem         <= pending_steps[0].elem;
                            priority_req <= pending_steps[0].prio;
                            nxt_start = 1'b1;
                            sent_cnt++;
                            void'(pending_steps.pop_front());
                        end
                        K_CFG:
                        begin
                            cfg_data <= pending_steps[0].prio;
                            nxt_we = 1'b1;
                            void'(pending_steps.pop_front());
                        end
                        default:
                        begin
                            if (due_results.size() == 0 && taken_cnt == sent_cnt)
                            begin
                                if (settle != 0)
                                    settle--;
                                else
                                begin
                                    settle = 2;
                                    void'(pending_steps.pop_front());
                                end
                            end
                        end
                    endcase
                end
            end
        end
        start  <= nxt_start;
        cfg_we <= nxt_we;
    end

    // monitor: results checked and transfers predicted on the rising edge
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $display("result %0d arrived with nothing outstanding", results_seen);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", 32'(status), 32'(want.status));
                    if (size !== want.size)
                        flag_mismatch("size", 32'(size), 32'(want.size));
                    if (empty_res !== want.empty)
                        flag_mismatch("empty_res", 32'(empty_res), 32'(want.empty));
                    if (head_elem !== want.head_elem)
                        flag_mismatch("head_elem", head_elem, want.head_elem);
                    if (head_priority !== want.head_prio)
                        flag_mismatch("head_priority", 32'(head_priority),
                                      32'(want.head_prio));
                end
                results_seen++;
            end
            if (cfg_we)
                cur_max_level = cfg_data;
            if (start && !busy)
            begin
                due_results.push_back(apply_request(op, elem, priority_req));
                taken_cnt++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int                phase;
        int                n;
        logic [PRIO_W-1:0] maxl;
        int                plan_len[8]  = '{320, 200, 200, 250, 300, 250, 300, 200};
        int                plan_enq[8]  = '{90, 40, 30, 60, 10, 50, 85, 30};
        int                plan_deq[8]  = '{5, 50, 60, 30, 85, 45, 10, 65};

        // empty queue corners
        add_item(OP_QUERY, ALL_ONES, 4'd15);
        add_item(OP_DEQ, '0, '0);
        add_item(OP_SPARE, 32'h1234_5678, 4'd3);
        // FIFO order within a level, lower level served first
        add_item(OP_ENQ, '0, 4'd15);
        add_item(OP_ENQ, ALL_ONES, 4'd0);
        add_item(OP_ENQ, 32'hA5A5_A5A5, 4'd0);
        add_item(OP_ENQ, 32'h5A5A_5A5A, 4'd7);
        add_item(OP_QUERY, '0, '0);
        repeat (4) add_item(OP_DEQ, ALL_ONES, 4'd15);
        add_item(OP_DEQ, '0, '0);

        // lowered max_level keeps what is already stored
        add_item(OP_ENQ, 32'hDEAD_BEEF, 4'd9);
        add_level_write(4'd3);
        add_item(OP_ENQ, 32'h0000_0001, 4'd9);
        add_item(OP_ENQ, 32'h8000_0000, 4'd3);
        add_item(OP_ENQ, 32'h0000_0002, 4'd4);
        add_item(OP_QUERY, '0, '0);
        add_item(OP_DEQ, '0, '0);
        add_item(OP_QUERY, '0, '0);
        add_item(OP_DEQ, '0, '0);

        add_level_write(4'd0);
        add_item(OP_ENQ, 32'hCAFE_F00D, 4'd1);
        add_item(OP_ENQ, 32'h7FFF_FFFF, 4'd0);
        add_item(OP_DEQ, '0, '0);

        // random phases: fill to full, drain to empty, mixed traffic
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0, 4, 6: maxl = 4'd15;
                2:       maxl = 4'd0;
                7:       maxl = 4'd8;
                default: maxl = PRIO_W'($urandom_range(1, 14));
            endcase
            add_level_write(maxl);
            for (n = 0; n < plan_len[phase]; n++)
                add_random(plan_enq[phase], plan_deq[phase], maxl);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_steps.size() != 0 || start)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_cell.sv
hw/rtl/bucketed_priority_fifo_queue_core.sv
hw/rtl/bpq_chk.sv
bench/tb_bucketed_priority_fifo_queue_core.sv
